// ===== src/scuf_pkg.sv =====
// Shared types and constants of the size-capped union-find block.
// Depends on nothing; every other file of the block but scuf_ram imports it.
`default_nettype none

package scuf_pkg;

  // Default node capacity of the store.
  localparam int NODES_DEF = 4096;

  // Fixed field widths of the channels.
  localparam int FUNC_W     = 1;
  localparam int NODE_W     = 12;
  localparam int CNT_W      = 13;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;

  // Request functions.
  localparam logic [FUNC_W-1:0] FUNC_MERGE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_MERGED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_SAME    = 3'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 3'd2;
  localparam logic [STAT_W-1:0] ST_STOPPED = 3'd3;
  localparam logic [STAT_W-1:0] ST_QUERY   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE   = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 13'd4096;
  localparam logic [CNT_W-1:0] TARGET_RST     = 13'd1000;
  localparam logic [CNT_W-1:0] MAX_SIZE_RST   = 13'd50;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_START_A,
    OP_START_B,
    OP_WALK_STEP,
    OP_ROOT_FOUND,
    OP_COMP_STEP,
    OP_RD_SZA,
    OP_CAP_SA,
    OP_CAP_SB,
    OP_MERGE,
    OP_ZERO
  } dp_op_t;

  // Source of the root and size fields of a result.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_A,
    RES_MERGE
  } res_sel_t;

  // Controller to datapath commands.
  typedef struct packed {
    dp_op_t              op;
    logic                res_load;
    logic [STAT_W-1:0]   res_status;
    res_sel_t            res_sel;
    logic                out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_query;
    logic stopped;
    logic a_ok;
    logic b_ok;
    logic hit;
    logic start_root;
    logic comp_end;
    logic sel_b;
    logic same;
    logic over;
    logic clr_last;
    logic reinit;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/scuf_ifs.sv =====
// Channel interfaces of the size-capped union-find block: request, result
// and configuration write. Depends on scuf_pkg for the field widths.
`default_nettype none

// Request channel: one merge or query.
interface scuf_in_if;
  import scuf_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, func, node_a, node_b, input ready);
  modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

// Result channel: one result per request.
interface scuf_out_if;
  import scuf_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [NODE_W-1:0] root;
  logic [CNT_W-1:0]  root_size;
  logic [CNT_W-1:0]  cluster_count;

  modport source (output valid, status, root, root_size, cluster_count, input ready);
  modport sink   (input valid, status, root, root_size, cluster_count, output ready);
endinterface

// Configuration write channel.
interface scuf_cfg_if;
  import scuf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/scuf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module scuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/scuf_ctrl.sv =====
// Controller of the size-capped union-find block: sequences clearing,
// root walks, path compression, size checks and result hand-off.
// Depends on scuf_pkg.
`default_nettype none

module scuf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output scuf_pkg::cmd_t      cmd,
  input  wire scuf_pkg::stat_t stat
);
  import scuf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_COMP,
    S_FIND_END,
    S_SZA,
    S_SZB,
    S_EVAL,
    S_ZERO,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{op: OP_NONE, res_load: 1'b0, res_status: ST_MERGED,
                      res_sel: RES_ZERO, out_load: 1'b0};
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_query) begin
          if (stat.a_ok) begin
            cmd.op    = OP_START_A;
            state_nxt = S_WALK;
          end else begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_QUERY;
            state_nxt      = S_OUT;
          end
        end else if (stat.stopped) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_STOPPED;
          state_nxt      = S_OUT;
        end else if (!(stat.a_ok && stat.b_ok)) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_REFUSED;
          state_nxt      = S_OUT;
        end else begin
          cmd.op    = OP_START_A;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.hit) begin
          cmd.op    = OP_ROOT_FOUND;
          state_nxt = stat.start_root ? S_FIND_END : S_COMP;
        end else begin
          cmd.op = OP_WALK_STEP;
        end
      end
      S_COMP: begin
        cmd.op = OP_COMP_STEP;
        if (stat.comp_end) begin
          state_nxt = S_FIND_END;
        end
      end
      S_FIND_END: begin
        if (!stat.is_query && !stat.sel_b) begin
          cmd.op    = OP_START_B;
          state_nxt = S_WALK;
        end else begin
          cmd.op    = OP_RD_SZA;
          state_nxt = S_SZA;
        end
      end
      S_SZA: begin
        cmd.op    = OP_CAP_SA;
        state_nxt = stat.is_query ? S_EVAL : S_SZB;
      end
      S_SZB: begin
        cmd.op    = OP_CAP_SB;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_A;
        state_nxt    = S_OUT;
        if (stat.is_query) begin
          cmd.res_status = ST_QUERY;
        end else if (stat.same) begin
          cmd.res_status = ST_SAME;
        end else if (stat.over) begin
          cmd.res_status = ST_REFUSED;
        end else begin
          cmd.op         = OP_MERGE;
          cmd.res_status = ST_MERGED;
          cmd.res_sel    = RES_MERGE;
          state_nxt      = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.op    = OP_ZERO;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // A node count write restarts the clearing pass.
    if (stat.reinit) begin
      state_nxt = S_CLEAR;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/scuf_dp.sv =====
// Datapath of the size-capped union-find block: configuration registers,
// parent and size memories, walk pointer, root and size registers, results.
// Depends on scuf_pkg and scuf_ram.
`default_nettype none

module scuf_dp #(
  parameter int NODES = scuf_pkg::NODES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scuf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scuf_pkg::CNT_W-1:0]     cfg_data,
  input  wire logic [scuf_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [scuf_pkg::NODE_W-1:0]    in_node_a,
  input  wire logic [scuf_pkg::NODE_W-1:0]    in_node_b,
  output logic      [scuf_pkg::STAT_W-1:0]    out_status,
  output logic      [scuf_pkg::NODE_W-1:0]    out_root,
  output logic      [scuf_pkg::CNT_W-1:0]     out_root_size,
  output logic      [scuf_pkg::CNT_W-1:0]     out_cluster_count,
  input  wire scuf_pkg::cmd_t                 cmd,
  output scuf_pkg::stat_t                     stat
);
  import scuf_pkg::*;

  localparam int IDX_W   = $clog2(NODES);
  localparam int SIZE_W  = $clog2(NODES + 1);
  localparam int SUM_W   = SIZE_W + 1;
  localparam int WIDE_W  = (SUM_W > CNT_W + 1) ? SUM_W : CNT_W + 1;
  localparam int RST_EFF = (int'(NODE_COUNT_RST) < NODES) ? int'(NODE_COUNT_RST) : NODES;

  // Configuration and control state.
  logic [CNT_W-1:0]  node_count_r;
  logic [CNT_W-1:0]  target_r;
  logic [CNT_W-1:0]  max_size_r;
  logic [SIZE_W-1:0] clusters_r;
  logic [IDX_W-1:0]  clr_idx_r;

  // Request and walk registers.
  logic [FUNC_W-1:0] func_r;
  logic [NODE_W-1:0] a_r;
  logic [NODE_W-1:0] b_r;
  logic [IDX_W-1:0]  cur_r;
  logic              sel_r;
  logic [IDX_W-1:0]  ra_r;
  logic [IDX_W-1:0]  rb_r;
  logic [SIZE_W-1:0] sa_r;
  logic [SIZE_W-1:0] sb_r;

  // Result and output registers.
  logic [STAT_W-1:0] res_status_r;
  logic [IDX_W-1:0]  res_root_r;
  logic [SIZE_W-1:0] res_size_r;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_root_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [SIZE_W-1:0] out_clusters_r;

  // Memory ports.
  logic              par_we;
  logic [IDX_W-1:0]  par_waddr;
  logic [IDX_W-1:0]  par_wdata;
  logic [IDX_W-1:0]  par_raddr;
  logic [IDX_W-1:0]  par_rdata;
  logic              sz_we;
  logic [IDX_W-1:0]  sz_waddr;
  logic [SIZE_W-1:0] sz_wdata;
  logic [IDX_W-1:0]  sz_raddr;
  logic [SIZE_W-1:0] sz_rdata;

  // Derived values.
  logic [WIDE_W-1:0] eff_n;
  logic [WIDE_W-1:0] cfg_eff;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  b_idx;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  root_sel;
  logic [SUM_W-1:0]  sum;
  logic [IDX_W-1:0]  winner;
  logic [IDX_W-1:0]  loser;
  logic              reinit;

  // Effective node count: the configured count capped at the capacity.
  assign eff_n   = (WIDE_W'(node_count_r) < WIDE_W'(NODES)) ? WIDE_W'(node_count_r)
                                                            : WIDE_W'(NODES);
  assign cfg_eff = (WIDE_W'(cfg_data) < WIDE_W'(NODES)) ? WIDE_W'(cfg_data)
                                                        : WIDE_W'(NODES);

  // Node indexes are only used once checked against the effective count.
  assign a_idx     = IDX_W'(a_r);
  assign b_idx     = IDX_W'(b_r);
  assign start_idx = sel_r ? b_idx : a_idx;
  assign root_sel  = sel_r ? rb_r : ra_r;

  // Union by size: on a tie the second root goes under the first.
  assign sum    = SUM_W'(sa_r) + SUM_W'(sb_r);
  assign winner = (sa_r < sb_r) ? rb_r : ra_r;
  assign loser  = (sa_r < sb_r) ? ra_r : rb_r;

  assign reinit    = cfg_valid && (cfg_index == CFG_NODE_COUNT);
  assign cfg_ready = 1'b1;

  // Memory port steering.
  always_comb begin
    par_we    = 1'b0;
    par_waddr = cur_r;
    par_wdata = root_sel;
    par_raddr = cur_r;
    sz_we     = 1'b0;
    sz_waddr  = winner;
    sz_wdata  = SIZE_W'(sum);
    sz_raddr  = ra_r;
    unique case (cmd.op)
      OP_CLR: begin
        par_we    = 1'b1;
        par_waddr = clr_idx_r;
        par_wdata = clr_idx_r;
        sz_we     = 1'b1;
        sz_waddr  = clr_idx_r;
        sz_wdata  = SIZE_W'(1);
      end
      OP_START_A:    par_raddr = a_idx;
      OP_START_B:    par_raddr = b_idx;
      OP_WALK_STEP:  par_raddr = par_rdata;
      OP_ROOT_FOUND: par_raddr = start_idx;
      OP_COMP_STEP: begin
        par_we    = 1'b1;
        par_raddr = par_rdata;
      end
      OP_RD_SZA:     sz_raddr = ra_r;
      OP_CAP_SA:     sz_raddr = rb_r;
      OP_MERGE: begin
        par_we    = 1'b1;
        par_waddr = loser;
        par_wdata = winner;
        sz_we     = 1'b1;
      end
      OP_ZERO: begin
        sz_we    = 1'b1;
        sz_waddr = loser;
        sz_wdata = '0;
      end
      default: begin
        par_we = 1'b0;
      end
    endcase
  end

  // Parent links.
  scuf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NODES)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  // Cluster sizes, held at the roots.
  scuf_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (NODES)
  ) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  // Configuration, cluster count and clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      target_r     <= TARGET_RST;
      max_size_r   <= MAX_SIZE_RST;
      clusters_r   <= SIZE_W'(RST_EFF);
      clr_idx_r    <= '0;
    end else begin
      if (cmd.op == OP_MERGE && clusters_r != '0) begin
        clusters_r <= clusters_r - SIZE_W'(1);
      end
      if (reinit) begin
        clr_idx_r <= '0;
      end else if (cmd.op == OP_CLR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: begin
            node_count_r <= cfg_data;
            clusters_r   <= SIZE_W'(cfg_eff);
          end
          CFG_TARGET:   target_r   <= cfg_data;
          CFG_MAX_SIZE: max_size_r <= cfg_data;
          default: begin
            target_r <= target_r;
          end
        endcase
      end
    end
  end

  // Request, walk and size registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        func_r <= in_func;
        a_r    <= in_node_a;
        b_r    <= in_node_b;
      end
      OP_START_A: begin
        cur_r <= a_idx;
        sel_r <= 1'b0;
      end
      OP_START_B: begin
        cur_r <= b_idx;
        sel_r <= 1'b1;
      end
      OP_WALK_STEP: cur_r <= par_rdata;
      OP_ROOT_FOUND: begin
        if (sel_r) begin
          rb_r <= cur_r;
        end else begin
          ra_r <= cur_r;
        end
        cur_r <= start_idx;
      end
      OP_COMP_STEP: cur_r <= par_rdata;
      OP_CAP_SA:    sa_r  <= sz_rdata;
      OP_CAP_SB:    sb_r  <= sz_rdata;
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  // Result staging and output register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      unique case (cmd.res_sel)
        RES_A: begin
          res_root_r <= ra_r;
          res_size_r <= sa_r;
        end
        RES_MERGE: begin
          res_root_r <= winner;
          res_size_r <= SIZE_W'(sum);
        end
        default: begin
          res_root_r <= '0;
          res_size_r <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r   <= res_status_r;
      out_root_r     <= res_root_r;
      out_size_r     <= res_size_r;
      out_clusters_r <= clusters_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_root          = NODE_W'(out_root_r);
  assign out_root_size     = CNT_W'(out_size_r);
  assign out_cluster_count = CNT_W'(out_clusters_r);

  // Status toward the controller.
  always_comb begin
    stat.is_query   = (func_r == FUNC_QUERY);
    stat.stopped    = (WIDE_W'(clusters_r) <= WIDE_W'(target_r));
    stat.a_ok       = (WIDE_W'(a_r) < eff_n);
    stat.b_ok       = (WIDE_W'(b_r) < eff_n);
    stat.hit        = (par_rdata == cur_r);
    stat.start_root = (start_idx == cur_r);
    stat.comp_end   = (par_rdata == root_sel);
    stat.sel_b      = sel_r;
    stat.same       = (ra_r == rb_r);
    stat.over       = (WIDE_W'(sum) > WIDE_W'(max_size_r));
    stat.clr_last   = (clr_idx_r == IDX_W'(NODES - 1));
    stat.reinit     = reinit;
  end

endmodule

`default_nettype wire

// ===== src/size_capped_union_find.sv =====
// Size-capped union-find store (union by size, full path compression).
// Channels: in_chan takes merge or query requests, out_chan returns one
// result per request, cfg_chan writes node_count, target_count, max_size.
// Cfg_chan is always ready; writes are meant for an idle block.
// Operation: a request is handled alone by one controller and datapath pair.
// A root walk over the parent memory follows one link at a time, and the
// compression pass rewrites one node at a time, both through the
// single read port of the parent memory. A merge adds to a query the walk
// and compression of the second node, the read of its root's size and the
// merge writes. Stopped and out-of-range requests skip the walks and go
// straight from the decision to the result. Union by size keeps the depth
// of any node within log2(NODES).
// The result sits in an output register: a stalled receiver does not hold
// up the next request, which is accepted as soon as the block is idle; its
// result waits until the register is taken.
// Reset, and every write of node_count, starts a clearing pass over all NODES
// entries that makes every node its own cluster of size one; no request is
// accepted during it, configuration writes still are.
// Depends on scuf_pkg, scuf_ifs, scuf_ctrl, scuf_dp and scuf_ram.
`default_nettype none

module size_capped_union_find #(
  parameter int NODES = scuf_pkg::NODES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  scuf_in_if.sink   in_chan,
  scuf_out_if.source out_chan,
  scuf_cfg_if.sink  cfg_chan
);
  import scuf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  scuf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Memories and registers.
  scuf_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_chan.valid),
    .cfg_ready         (cfg_chan.ready),
    .cfg_index         (cfg_chan.index),
    .cfg_data          (cfg_chan.data),
    .in_func           (in_chan.func),
    .in_node_a         (in_chan.node_a),
    .in_node_b         (in_chan.node_b),
    .out_status        (out_chan.status),
    .out_root          (out_chan.root),
    .out_root_size     (out_chan.root_size),
    .out_cluster_count (out_chan.cluster_count),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire
